>>> src/gre_pkg.sv
// Shared types and constants for the graph reachability engine.
// Holds the transfer payload structs and the controller/datapath interface types.
// No dependencies.
package gre_pkg;

  localparam int MAX_VERTS = 64;
  localparam int VERT_W    = $clog2(MAX_VERTS);
  localparam int COUNT_W   = $clog2(MAX_VERTS + 1);

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(MAX_VERTS);

  // Command codes carried in the request payload.
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_EDGE  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  typedef logic [MAX_VERTS-1:0] vset_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [VERT_W-1:0] vertex_a;
    logic [VERT_W-1:0] vertex_b;
  } req_t;

  typedef struct packed {
    logic path_found;
    logic bad_vertex;
  } rsp_t;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_CLEAR,
    DP_LOAD_E,
    DP_LOAD_Q,
    DP_RD_A,
    DP_WR_A,
    DP_RD_B,
    DP_WR_B
  } dp_op_t;

  // The query step is the only other datapath operation; it reuses the op field.
  localparam dp_op_t DP_STEP = dp_op_t'(3'd0);

  typedef struct packed {
    dp_op_t op;
    logic   step;
  } dp_cmd_t;

  typedef struct packed {
    logic in_bad;
    logic cand_any;
    logic rd_pend;
    logic hit;
  } dp_stat_t;

endpackage

>>> src/gre_dp.sv
// Datapath of the graph reachability engine: adjacency memory, row valid bits,
// reached/expanded sets, vertex count register. Depends on gre_pkg.
module gre_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [gre_pkg::COUNT_W-1:0] cfg_wr_data,
  input  gre_pkg::req_t         req,
  input  gre_pkg::dp_cmd_t      cmd,
  output gre_pkg::dp_stat_t     stat
);
  import gre_pkg::*;

  logic [COUNT_W-1:0] vertex_count;
  logic [COUNT_W-1:0] n_eff;
  vset_t              valid_mask;

  logic [VERT_W-1:0]  va;
  logic [VERT_W-1:0]  vb;
  vset_t              reached;
  vset_t              expanded;
  logic               rd_pend;
  vset_t              row_valid;

  vset_t              mem [MAX_VERTS];
  vset_t              mem_q;
  logic               rvld_q;

  vset_t              cand;
  logic [VERT_W-1:0]  pick;
  logic [VERT_W-1:0]  raddr;
  logic               we;
  logic [VERT_W-1:0]  waddr;
  vset_t              wdata;
  vset_t              row_data;

  always_comb begin
    n_eff = (vertex_count > COUNT_W'(MAX_VERTS)) ? COUNT_W'(MAX_VERTS) : vertex_count;
    for (int i = 0; i < MAX_VERTS; i++) begin
      valid_mask[i] = (COUNT_W'(i) < n_eff);
    end
  end

  // Lowest reached vertex that has not been expanded yet.
  always_comb begin
    cand = reached & ~expanded & valid_mask;
    pick = '0;
    for (int i = MAX_VERTS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pick = VERT_W'(i);
      end
    end
  end

  assign row_data = rvld_q ? mem_q : '0;

  always_comb begin
    raddr = pick;
    we    = 1'b0;
    waddr = va;
    wdata = row_data | (vset_t'(1) << vb);
    if (!cmd.step) begin
      unique case (cmd.op)
        DP_RD_A: raddr = va;
        DP_RD_B: raddr = vb;
        DP_WR_A: begin
          we = 1'b1;
        end
        DP_WR_B: begin
          we    = 1'b1;
          waddr = vb;
          wdata = row_data | (vset_t'(1) << va);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q  <= mem[raddr];
    rvld_q <= row_valid[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= COUNT_RESET;
      row_valid    <= '0;
      reached      <= '0;
      expanded     <= '0;
      rd_pend      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        vertex_count <= cfg_wr_data;
      end
      // A row read is pending for the cycle after a step that picked a vertex.
      rd_pend <= cmd.step && (cand != '0);
      if (we) begin
        row_valid[waddr] <= 1'b1;
      end
      if (cmd.step) begin
        if (rd_pend) begin
          reached <= reached | (row_data & valid_mask);
        end
        if (cand != '0) begin
          expanded[pick] <= 1'b1;
        end
      end else begin
        unique case (cmd.op)
          DP_CLEAR: begin
            row_valid <= '0;
            reached   <= '0;
            expanded  <= '0;
          end
          DP_LOAD_Q: begin
            reached  <= vset_t'(1) << req.vertex_a;
            expanded <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!cmd.step && (cmd.op == DP_LOAD_E || cmd.op == DP_LOAD_Q)) begin
      va <= req.vertex_a;
      vb <= req.vertex_b;
    end
  end

  assign stat.in_bad   = ({1'b0, req.vertex_a} >= n_eff) || ({1'b0, req.vertex_b} >= n_eff);
  assign stat.cand_any = (cand != '0);
  assign stat.rd_pend  = rd_pend;
  assign stat.hit      = reached[vb];

endmodule

>>> src/gre_ctrl.sv
// Controller of the graph reachability engine: command sequencing and the
// registered response slot. Depends on gre_pkg.
module gre_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [1:0]        req_cmd,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output gre_pkg::rsp_t     rsp,
  output gre_pkg::dp_cmd_t  cmd,
  input  gre_pkg::dp_stat_t stat
);
  import gre_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_A,
    S_WR_A,
    S_RD_B,
    S_WR_B,
    S_QUERY,
    S_REPLY
  } state_t;

  state_t state;
  rsp_t   res;
  logic   accept;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;

  always_comb begin
    cmd.op   = DP_NOP;
    cmd.step = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority if (req_cmd == CMD_CLEAR) begin
            cmd.op = DP_CLEAR;
          end else if (req_cmd == CMD_EDGE && !stat.in_bad) begin
            cmd.op = DP_LOAD_E;
          end else if (req_cmd == CMD_QUERY && !stat.in_bad) begin
            cmd.op = DP_LOAD_Q;
          end else begin
            cmd.op = DP_NOP;
          end
        end
      end
      S_RD_A:  cmd.op = DP_RD_A;
      S_WR_A:  cmd.op = DP_WR_A;
      S_RD_B:  cmd.op = DP_RD_B;
      S_WR_B:  cmd.op = DP_WR_B;
      S_QUERY: begin
        cmd.op   = DP_STEP;
        cmd.step = 1'b1;
      end
      default: cmd.op = DP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      res       <= '0;
      rsp       <= '0;
    end else begin
      // In the reply state the slot is either refilled or left waiting.
      if (rsp_valid && rsp_ready && state != S_REPLY) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res.path_found <= 1'b0;
            res.bad_vertex <= (req_cmd == CMD_EDGE || req_cmd == CMD_QUERY) && stat.in_bad;
            if (req_cmd == CMD_EDGE && !stat.in_bad) begin
              state <= S_RD_A;
            end else if (req_cmd == CMD_QUERY && !stat.in_bad) begin
              state <= S_QUERY;
            end else begin
              state <= S_REPLY;
            end
          end
        end
        S_RD_A: state <= S_WR_A;
        S_WR_A: state <= S_RD_B;
        S_RD_B: state <= S_WR_B;
        S_WR_B: state <= S_REPLY;
        S_QUERY: begin
          if (stat.hit) begin
            res.path_found <= 1'b1;
            state          <= S_REPLY;
          end else if (!stat.cand_any && !stat.rd_pend) begin
            state <= S_REPLY;
          end
        end
        S_REPLY: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid <= 1'b1;
            rsp       <= res;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> src/graph_reachability_engine.sv
// Graph reachability engine top level: undirected graph over up to 64 vertices.
// Clear and rejected commands go straight to the reply state, an edge insert passes through
// S_RD_A to S_WR_B, and a query reads one row per cycle while a vertex awaits expansion and
// merges it the cycle after. One item is in work at a time; the next is taken once the reply
// sits in the output register. Reset (rst, synchronous) empties the graph via row valid bits,
// with no clearing pass, and sets vertex_count to 64. Depends on gre_pkg, gre_ctrl and gre_dp.
module graph_reachability_engine (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [gre_pkg::COUNT_W-1:0] cfg_wr_data,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  gre_pkg::req_t               req,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output gre_pkg::rsp_t               rsp
);
  import gre_pkg::*;

  // The controller sequences each request transfer into datapath operations:
  // an edge is two read-modify-write passes over the adjacency memory, and a
  // query expands one reached vertex per cycle while one is ready, until the
  // target shows up or no unexpanded vertex or pending row is left. Replies
  // leave from a register in the controller; a new reply waits while it is full.
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  gre_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_cmd   (req.cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cmd       (dp_cmd),
    .stat      (dp_stat)
  );

  // The datapath holds the vertex count register, the adjacency rows and the
  // search sets. Rows that were never written since the last clear read as zero.
  gre_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req),
    .cmd         (dp_cmd),
    .stat        (dp_stat)
  );

endmodule

>>> tb/sv/gre_checker.sv
// Checker for the graph reachability engine: watches the configuration port and both
// transfer channels, predicts every response and compares it field by field.
// Depends on gre_pkg for the payload types, command codes and sizes.
module gre_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [gre_pkg::COUNT_W-1:0] cfg_wr_data,
  input  logic                        req_valid,
  input  logic                        req_ready,
  input  gre_pkg::req_t               req,
  input  logic                        rsp_valid,
  input  logic                        rsp_ready,
  input  gre_pkg::rsp_t               rsp,
  output int unsigned                 mismatches,
  output int unsigned                 outstanding
);
  import gre_pkg::*;

  vset_t              adj_rows [MAX_VERTS];
  logic [COUNT_W-1:0] vcount;
  rsp_t               expected_rsps [$];
  rsp_t               want;
  rsp_t               predicted;

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("gre_checker: %s at %0t", msg, $time);
    end
  endtask

  // Frontier expansion over the live vertices: expand the lowest reached vertex
  // that has not been expanded yet until the target shows up or nothing is left.
  function automatic logic path_exists(input int unsigned src, input int unsigned dst,
                                       input int unsigned n);
    vset_t       reached;
    vset_t       expanded;
    vset_t       live;
    int unsigned pick;
    logic        found;
    logic        done;
    live     = (n >= MAX_VERTS) ? '1 : ((vset_t'(1) << n) - vset_t'(1));
    reached  = '0;
    expanded = '0;
    reached[src] = 1'b1;
    found = (src == dst);
    done  = found;
    while (!done) begin
      pick = n;
      for (int unsigned i = 0; i < n; i++) begin
        if (pick == n && reached[i] && !expanded[i]) pick = i;
      end
      if (pick >= n) begin
        done = 1'b1;
      end else begin
        expanded[pick] = 1'b1;
        reached = reached | (adj_rows[pick] & live);
        if (reached[dst]) begin
          found = 1'b1;
          done  = 1'b1;
        end
      end
    end
    return found;
  endfunction

  task automatic apply_cmd(input req_t r, output rsp_t res);
    int unsigned n;
    logic        out_of_range;
    n = (vcount > MAX_VERTS) ? MAX_VERTS : vcount;
    out_of_range = (r.vertex_a >= n) || (r.vertex_b >= n);
    res = '0;
    case (r.cmd)
      CMD_CLEAR: begin
        for (int i = 0; i < MAX_VERTS; i++) adj_rows[i] = '0;
      end
      CMD_EDGE: begin
        if (out_of_range) begin
          res.bad_vertex = 1'b1;
        end else begin
          adj_rows[r.vertex_a][r.vertex_b] = 1'b1;
          adj_rows[r.vertex_b][r.vertex_a] = 1'b1;
        end
      end
      CMD_QUERY: begin
        if (out_of_range) begin
          res.bad_vertex = 1'b1;
        end else begin
          res.path_found = path_exists(r.vertex_a, r.vertex_b, n);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_VERTS; i++) adj_rows[i] = '0;
      vcount = COUNT_RESET;
      expected_rsps.delete();
    end else begin
      if (cfg_wr_en) vcount = cfg_wr_data;
      // Responses are matched first so that an empty queue really means unexpected.
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          note_mismatch($sformatf("response %b/%b with no request waiting",
                                  rsp.path_found, rsp.bad_vertex));
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.path_found !== want.path_found) begin
            note_mismatch($sformatf("path_found expected %b got %b",
                                    want.path_found, rsp.path_found));
          end
          if (rsp.bad_vertex !== want.bad_vertex) begin
            note_mismatch($sformatf("bad_vertex expected %b got %b",
                                    want.bad_vertex, rsp.bad_vertex));
          end
        end
      end
      if (req_valid && req_ready) begin
        apply_cmd(req, predicted);
        expected_rsps.push_back(predicted);
      end
    end
    outstanding = expected_rsps.size();
  end

endmodule

>>> tb/sv/testbench.sv
// Top of the graph reachability engine testbench: clock, reset, stimulus, receiver
// back-pressure, watchdog and the final verdict. Prediction lives in gre_checker.
// Depends on gre_pkg, gre_checker and graph_reachability_engine.
module testbench;
  import gre_pkg::*;

  // The fourth command code is not used by the block; it must answer 0,0 and change nothing.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int ITEMS_PER_PHASE = 350;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 8;
  localparam int END_CYCLES      = 80;
  localparam int WATCHDOG_LIMIT  = 4000;

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic [COUNT_W-1:0] cfg_wr_data;
  logic               req_valid;
  logic               req_ready;
  req_t               req;
  logic               rsp_valid;
  logic               rsp_ready;
  rsp_t               rsp;

  int unsigned mismatches;
  int unsigned outstanding;

  // Idle percentages for the sender and the receiver; the stimulus changes them per phase.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  // Set by the stimulus to ask the receiver for one long hold-off.
  logic        hold_request;
  // Effective vertex count as last written, used only to shape the stimulus.
  int unsigned live_count;

  graph_reachability_engine u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp)
  );

  gre_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Receiver. Ready changes only at the falling edge. A hold-off request turns ready
  // off for a fixed stretch that this process counts itself; otherwise ready is drawn
  // at random against the current idle percentage.
  initial begin
    int unsigned hold_left;
    logic        hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    rsp_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        rsp_ready <= 1'b0;
        hold_left--;
      end else if (hold_request && !hold_taken) begin
        rsp_ready <= 1'b0;
        hold_left = HOLD_CYCLES;
        hold_taken = 1'b1;
      end else begin
        rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog. Any transfer on either channel restarts the count, so only a real hang
  // (or a lost response that is waited for at the end) can reach the limit.
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("[graph_reachability_engine] ERROR");
    $finish;
  end

  function automatic req_t make_cmd(input logic [1:0] cmd, input int unsigned a,
                                    input int unsigned b);
    req_t r;
    r.cmd      = cmd;
    r.vertex_a = VERT_W'(a);
    r.vertex_b = VERT_W'(b);
    return r;
  endfunction

  // Mostly a vertex inside the live range, now and then any index at all so that
  // rejected edges and queries keep turning up.
  function automatic int unsigned pick_vertex(input int unsigned n);
    if (n == 0 || $urandom_range(9) == 0) return $urandom_range(MAX_VERTS - 1);
    return $urandom_range(n - 1);
  endfunction

  // The random mix is dominated by edges and queries so that graphs grow deep enough
  // for long searches; clears and the unused code are sprinkled in as noise.
  function automatic req_t random_cmd(input int unsigned n);
    int unsigned roll;
    logic [1:0]  cmd;
    roll = $urandom_range(99);
    if (roll < 3)       cmd = CMD_CLEAR;
    else if (roll < 6)  cmd = CMD_UNUSED;
    else if (roll < 50) cmd = CMD_EDGE;
    else                cmd = CMD_QUERY;
    return make_cmd(cmd, pick_vertex(n), pick_vertex(n));
  endfunction

  // One request transfer. Called at a falling edge and returns at the falling edge
  // after the transfer, leaving valid high so that back-to-back items never drop it.
  task automatic send_cmd(input req_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering and wait until the checker holds no expectation, then let the
  // block settle. Every configuration write goes through here first.
  task automatic drain_and_pause(input int unsigned settle_cycles);
    req_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (settle_cycles) @(negedge clk);
  endtask

  task automatic write_vertex_count(input int unsigned value);
    cfg_wr_data <= COUNT_W'(value);
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    live_count = (value > MAX_VERTS) ? MAX_VERTS : value;
  endtask

  initial begin
    int unsigned sent;
    int unsigned block_len;
    int unsigned roll;
    int unsigned count_value;
    logic        held;

    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    req_valid     = 1'b0;
    req           = '0;
    hold_request  = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    live_count    = MAX_VERTS;
    held          = 1'b0;

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part with the reset count of 64. A query from a vertex to itself is
    // found on an empty graph, an edge is seen from both ends, and a self loop
    // leads nowhere.
    send_cmd(make_cmd(CMD_QUERY, 0, 0));
    send_cmd(make_cmd(CMD_QUERY, 0, 63));
    send_cmd(make_cmd(CMD_EDGE, 0, 63));
    send_cmd(make_cmd(CMD_QUERY, 63, 0));
    send_cmd(make_cmd(CMD_EDGE, 5, 5));
    send_cmd(make_cmd(CMD_QUERY, 5, 6));
    send_cmd(make_cmd(CMD_EDGE, 1, 2));
    send_cmd(make_cmd(CMD_EDGE, 2, 3));
    send_cmd(make_cmd(CMD_QUERY, 1, 3));
    send_cmd(make_cmd(CMD_UNUSED, 63, 63));
    send_cmd(make_cmd(CMD_EDGE, 10, 40));
    send_cmd(make_cmd(CMD_EDGE, 40, 11));

    // Lowering the count keeps the edges but hides vertex 40, which cuts the path
    // from 10 to 11; naming 40 or 45 is now rejected.
    drain_and_pause(DRAIN_CYCLES);
    write_vertex_count(30);
    send_cmd(make_cmd(CMD_QUERY, 10, 11));
    send_cmd(make_cmd(CMD_QUERY, 10, 40));
    send_cmd(make_cmd(CMD_EDGE, 45, 3));

    // Raising it again brings the stored path back; a clear then empties the graph.
    drain_and_pause(DRAIN_CYCLES);
    write_vertex_count(64);
    send_cmd(make_cmd(CMD_QUERY, 10, 11));
    send_cmd(make_cmd(CMD_CLEAR, 0, 0));
    send_cmd(make_cmd(CMD_QUERY, 0, 63));

    // A count of zero rejects every vertex.
    drain_and_pause(DRAIN_CYCLES);
    write_vertex_count(0);
    send_cmd(make_cmd(CMD_EDGE, 0, 0));
    send_cmd(make_cmd(CMD_QUERY, 0, 0));

    // The largest count behaves as 64.
    drain_and_pause(DRAIN_CYCLES);
    write_vertex_count(127);
    send_cmd(make_cmd(CMD_EDGE, 62, 63));
    send_cmd(make_cmd(CMD_QUERY, 63, 62));

    // With one vertex only vertex 0 exists.
    drain_and_pause(DRAIN_CYCLES);
    write_vertex_count(1);
    send_cmd(make_cmd(CMD_QUERY, 0, 0));
    send_cmd(make_cmd(CMD_EDGE, 0, 1));

    // Random part in three phases: sender mostly busy and receiver mostly idle, then
    // the reverse, then neither idles. Each phase is split into blocks; before each
    // block the sender waits for every response, so the vertex count can change.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 36;
          recv_idle_pct = 81;
        end
        1: begin
          send_idle_pct = 81;
          recv_idle_pct = 36;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        drain_and_pause(DRAIN_CYCLES);
        // About half the counts are 12 or below so components merge and searches run deep; the
        // extremes and counts above the vertex limit still come up regularly.
        roll = $urandom_range(19);
        if (roll == 0)      count_value = 0;
        else if (roll == 1) count_value = 64;
        else if (roll == 2) count_value = $urandom_range(127, 65);
        else if (roll == 3) count_value = 1;
        else if (roll < 12) count_value = $urandom_range(12, 2);
        else                count_value = $urandom_range(63, 13);
        write_vertex_count(count_value);
        if ($urandom_range(3) == 0) begin
          send_cmd(make_cmd(CMD_CLEAR, $urandom_range(63), $urandom_range(63)));
          sent++;
        end
        // Once, early on, the receiver holds off for a long stretch while the sender
        // keeps offering, so the block fills and must stall its input.
        if (phase == 0 && sent > 0 && !held) begin
          hold_request = 1'b1;
          held = 1'b1;
        end
        block_len = $urandom_range(80, 20);
        repeat (block_len) begin
          send_cmd(random_cmd(live_count));
          sent++;
        end
      end
    end

    drain_and_pause(END_CYCLES);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[graph_reachability_engine] OK");
    end else begin
      $display("[graph_reachability_engine] ERROR");
    end
    $finish;
  end

endmodule
